// ----- sv/clkalm_pkg.sv -----
`default_nettype none

package clkalm_pkg;

   localparam int unsigned DIGIT_COUNT = 4;
   localparam int unsigned SCAN_WIDTH  = $clog2(DIGIT_COUNT);

   // scan positions
   localparam logic [SCAN_WIDTH-1:0] POS_HOUR_TENS   = 2'd0;
   localparam logic [SCAN_WIDTH-1:0] POS_HOUR_ONES   = 2'd1;
   localparam logic [SCAN_WIDTH-1:0] POS_MINUTE_TENS = 2'd2;
   localparam logic [SCAN_WIDTH-1:0] POS_MINUTE_ONES = 2'd3;

   typedef struct packed {
      logic second_strobe;
      logic minute_strobe;
      logic minute_button;
      logic hour_button;
      logic alarm_button;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]             segment_pattern;
      logic [DIGIT_COUNT-1:0] digit_select;
   } rsp_payload_type;

   // segments a..g on bits 0..6, active high; codes above nine are dark
   function automatic logic [6:0] seg_font(input logic [3:0] value);
      logic [6:0] seg;
      case (value)
         4'd0:    seg = 7'h3F;
         4'd1:    seg = 7'h06;
         4'd2:    seg = 7'h5B;
         4'd3:    seg = 7'h4F;
         4'd4:    seg = 7'h66;
         4'd5:    seg = 7'h6D;
         4'd6:    seg = 7'h7D;
         4'd7:    seg = 7'h07;
         4'd8:    seg = 7'h7F;
         4'd9:    seg = 7'h6F;
         default: seg = 7'h00;
      endcase
      return seg;
   endfunction

endpackage

`default_nettype wire

// ----- sv/clkalm_if.sv -----
`default_nettype none

interface clkalm_req_if
   import clkalm_pkg::*;
();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface clkalm_rsp_if
   import clkalm_pkg::*;
();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- sv/clock_alarm_seven_segment_scanner_unit.sv -----
// 24-hour BCD clock with alarm time, driving a four-digit multiplexed
// seven-segment display.
//
// req_chan carries one tick per transfer: second and minute strobes and the
// minute, hour and alarm buttons. rsp_chan returns one transfer per tick:
// the segment pattern (a..g on bits 0..6, colon dot on bit 7) and the
// one-hot digit select for the digit being driven.
//
// The tick is captured in an input register; once the output register is
// free, the time counters update and the decoded digit is registered into
// the output register. One tick is taken every cycle while the response
// side keeps up.
//
// Reset clears both times to 00:00, the colon and the scan position, and
// empties both registers. When rsp_chan stalls, the output register holds
// its result, the input register holds the next tick, and req_chan.ready
// drops once both are full.
`default_nettype none

module clock_alarm_seven_segment_scanner_unit
   import clkalm_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   clkalm_req_if.sink   req_chan,
   clkalm_rsp_if.source rsp_chan
);

   // input register
   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff;

   // time state
   logic [1:0] clock_hour_tens_ff, clock_hour_tens_in;
   logic [3:0] clock_hour_ones_ff, clock_hour_ones_in;
   logic [2:0] clock_minute_tens_ff, clock_minute_tens_in;
   logic [3:0] clock_minute_ones_ff, clock_minute_ones_in;
   logic [1:0] alarm_hour_tens_ff, alarm_hour_tens_in;
   logic [3:0] alarm_hour_ones_ff, alarm_hour_ones_in;
   logic [2:0] alarm_minute_tens_ff, alarm_minute_tens_in;
   logic [3:0] alarm_minute_ones_ff, alarm_minute_ones_in;
   logic       colon_on_ff, colon_on_in;
   logic [SCAN_WIDTH-1:0] scan_digit_ff, scan_digit_in;

   // output register
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_data_ff, out_data_in;

   logic out_free;
   logic advance;

   // working values for the selected time
   logic [1:0] cur_ht, hr1_ht, new_ht;
   logic [3:0] cur_ho, hr1_ho, new_ho;
   logic [2:0] cur_mt, new_mt;
   logic [3:0] cur_mo, new_mo;
   logic       minute_step, minute_wrap, hour_step1, hour_step2;
   logic [3:0] shown_value;
   logic [6:0] shown_seg;

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      cur_ht = in_data_ff.alarm_button ? alarm_hour_tens_ff   : clock_hour_tens_ff;
      cur_ho = in_data_ff.alarm_button ? alarm_hour_ones_ff   : clock_hour_ones_ff;
      cur_mt = in_data_ff.alarm_button ? alarm_minute_tens_ff : clock_minute_tens_ff;
      cur_mo = in_data_ff.alarm_button ? alarm_minute_ones_ff : clock_minute_ones_ff;

      minute_step = in_data_ff.minute_strobe || in_data_ff.minute_button;
      minute_wrap = minute_step && (cur_mt == 3'd5) && (cur_mo == 4'd9);

      // minutes: wrap 59 to 00, else carry ones into tens
      new_mt = cur_mt;
      new_mo = cur_mo;
      if (minute_step) begin
         if (minute_wrap) begin
            new_mt = 3'd0;
            new_mo = 4'd0;
         end else if (cur_mo == 4'd9) begin
            new_mt = cur_mt + 3'd1;
            new_mo = 4'd0;
         end else begin
            new_mo = cur_mo + 4'd1;
         end
      end

      // hours may advance twice: once from the minute wrap, once from the button
      hour_step1 = minute_wrap || in_data_ff.hour_button;
      hour_step2 = minute_wrap && in_data_ff.hour_button;

      hr1_ht = cur_ht;
      hr1_ho = cur_ho;
      if (hour_step1) begin
         if ((cur_ht == 2'd2) && (cur_ho == 4'd3)) begin
            hr1_ht = 2'd0;
            hr1_ho = 4'd0;
         end else if (cur_ho == 4'd9) begin
            hr1_ht = cur_ht + 2'd1;
            hr1_ho = 4'd0;
         end else begin
            hr1_ho = cur_ho + 4'd1;
         end
      end

      new_ht = hr1_ht;
      new_ho = hr1_ho;
      if (hour_step2) begin
         if ((hr1_ht == 2'd2) && (hr1_ho == 4'd3)) begin
            new_ht = 2'd0;
            new_ho = 4'd0;
         end else if (hr1_ho == 4'd9) begin
            new_ht = hr1_ht + 2'd1;
            new_ho = 4'd0;
         end else begin
            new_ho = hr1_ho + 4'd1;
         end
      end
   end

   always_comb begin
      clock_hour_tens_in   = clock_hour_tens_ff;
      clock_hour_ones_in   = clock_hour_ones_ff;
      clock_minute_tens_in = clock_minute_tens_ff;
      clock_minute_ones_in = clock_minute_ones_ff;
      alarm_hour_tens_in   = alarm_hour_tens_ff;
      alarm_hour_ones_in   = alarm_hour_ones_ff;
      alarm_minute_tens_in = alarm_minute_tens_ff;
      alarm_minute_ones_in = alarm_minute_ones_ff;
      colon_on_in          = colon_on_ff;
      scan_digit_in        = scan_digit_ff;
      if (advance) begin
         if (in_data_ff.alarm_button) begin
            alarm_hour_tens_in   = new_ht;
            alarm_hour_ones_in   = new_ho;
            alarm_minute_tens_in = new_mt;
            alarm_minute_ones_in = new_mo;
         end else begin
            clock_hour_tens_in   = new_ht;
            clock_hour_ones_in   = new_ho;
            clock_minute_tens_in = new_mt;
            clock_minute_ones_in = new_mo;
         end
         colon_on_in   = colon_on_ff ^ in_data_ff.second_strobe;
         scan_digit_in = scan_digit_ff + 1'b1;
      end
   end

   always_comb begin
      case (scan_digit_ff)
         POS_HOUR_TENS:   shown_value = {2'b00, new_ht};
         POS_HOUR_ONES:   shown_value = new_ho;
         POS_MINUTE_TENS: shown_value = {1'b0, new_mt};
         POS_MINUTE_ONES: shown_value = new_mo;
         default:         shown_value = new_mo;
      endcase

      // blank a leading zero in the hours tens
      if ((scan_digit_ff == POS_HOUR_TENS) && (shown_value == 4'd0)) begin
         shown_seg = 7'h00;
      end else begin
         shown_seg = seg_font(shown_value);
      end

      out_data_in.segment_pattern = {colon_on_in, shown_seg};
      out_data_in.digit_select    = DIGIT_COUNT'(1) << scan_digit_ff;

      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
         clock_hour_tens_ff   <= '0;
         clock_hour_ones_ff   <= '0;
         clock_minute_tens_ff <= '0;
         clock_minute_ones_ff <= '0;
         alarm_hour_tens_ff   <= '0;
         alarm_hour_ones_ff   <= '0;
         alarm_minute_tens_ff <= '0;
         alarm_minute_ones_ff <= '0;
         colon_on_ff          <= 1'b0;
         scan_digit_ff        <= '0;
      end else begin
         in_valid_ff          <= in_valid_in;
         out_valid_ff         <= out_valid_in;
         clock_hour_tens_ff   <= clock_hour_tens_in;
         clock_hour_ones_ff   <= clock_hour_ones_in;
         clock_minute_tens_ff <= clock_minute_tens_in;
         clock_minute_ones_ff <= clock_minute_ones_in;
         alarm_hour_tens_ff   <= alarm_hour_tens_in;
         alarm_hour_ones_ff   <= alarm_hour_ones_in;
         alarm_minute_tens_ff <= alarm_minute_tens_in;
         alarm_minute_ones_ff <= alarm_minute_ones_in;
         colon_on_ff          <= colon_on_in;
         scan_digit_ff        <= scan_digit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         in_data_ff <= req_chan.payload;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   a_digit_onehot: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> $onehot(out_data_ff.digit_select))
      else $error("digit select not one-hot");

   a_scan_advance: assert property (@(posedge clock) disable iff (reset)
      advance |=> scan_digit_ff == $past(scan_digit_ff) + 1'b1)
      else $error("scan position did not advance on a tick");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("processed tick produced no result");

   a_hours_range: assert property (@(posedge clock) disable iff (reset)
      (clock_hour_tens_ff != 2'd3) && (alarm_hour_tens_ff != 2'd3))
      else $error("hour tens out of range");

   a_minutes_range: assert property (@(posedge clock) disable iff (reset)
      (clock_minute_tens_ff < 3'd6) && (alarm_minute_tens_ff < 3'd6))
      else $error("minute tens out of range");

endmodule

`default_nettype wire

// ----- tb/clock_alarm_seven_segment_scanner_unit_tb.sv -----
`timescale 1ns / 100ps

module clock_alarm_seven_segment_scanner_unit_tb;
   import clkalm_pkg::*;

   localparam int unsigned RANDOM_TICKS = 650;
   localparam int unsigned DRAIN_CYCLES = 8;

   typedef struct packed {
      logic [1:0] hour_tens;
      logic [3:0] hour_ones;
      logic [2:0] minute_tens;
      logic [3:0] minute_ones;
   } bcd_time_type;

   // segments a..g for the decimal digits
   localparam logic [6:0] DIGIT_GLYPH [10] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   clkalm_req_if req_if ();
   clkalm_rsp_if rsp_if ();

   clock_alarm_seven_segment_scanner_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   req_payload_type       tick_queue [$];
   rsp_payload_type       expected_frames [$];
   bcd_time_type          wall_time;
   bcd_time_type          alarm_time;
   logic                  colon_lit;
   logic [SCAN_WIDTH-1:0] scan_pos;
   logic                  req_fire = 1'b0;
   int unsigned           send_idle = 0;
   int unsigned           send_calm = 0;
   int unsigned           recv_idle = 0;
   int unsigned           recv_calm = 0;
   int unsigned           mismatch_count = 0;
   rsp_payload_type       want;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic bcd_time_type next_hour(input bcd_time_type t);
      bcd_time_type n;
      n = t;
      if (t.hour_tens == 2'd2 && t.hour_ones == 4'd3) begin
         n.hour_tens = 2'd0;
         n.hour_ones = 4'd0;
      end else if (t.hour_ones == 4'd9) begin
         n.hour_tens = t.hour_tens + 2'd1;
         n.hour_ones = 4'd0;
      end else begin
         n.hour_ones = t.hour_ones + 4'd1;
      end
      return n;
   endfunction

   function automatic bcd_time_type next_minute(input bcd_time_type t);
      bcd_time_type n;
      n = t;
      if (t.minute_tens == 3'd5 && t.minute_ones == 4'd9) begin
         n.minute_tens = 3'd0;
         n.minute_ones = 4'd0;
         n = next_hour(n);
      end else if (t.minute_ones == 4'd9) begin
         n.minute_tens = t.minute_tens + 3'd1;
         n.minute_ones = 4'd0;
      end else begin
         n.minute_ones = t.minute_ones + 4'd1;
      end
      return n;
   endfunction

   // update the time being set, then decode the digit under the scan
   function automatic rsp_payload_type render_tick(input req_payload_type tick);
      bcd_time_type    shown;
      logic [3:0]      digit;
      rsp_payload_type frame;
      shown = tick.alarm_button ? alarm_time : wall_time;
      if (tick.second_strobe)
         colon_lit = ~colon_lit;
      if (tick.minute_strobe || tick.minute_button)
         shown = next_minute(shown);
      if (tick.hour_button)
         shown = next_hour(shown);
      if (tick.alarm_button)
         alarm_time = shown;
      else
         wall_time = shown;
      case (scan_pos)
         POS_HOUR_TENS:   digit = {2'b00, shown.hour_tens};
         POS_HOUR_ONES:   digit = shown.hour_ones;
         POS_MINUTE_TENS: digit = {1'b0, shown.minute_tens};
         default:         digit = shown.minute_ones;
      endcase
      if (digit > 4'd9 || (scan_pos == POS_HOUR_TENS && digit == 4'd0))
         frame.segment_pattern[6:0] = 7'h00;
      else
         frame.segment_pattern[6:0] = DIGIT_GLYPH[digit];
      frame.segment_pattern[7] = colon_lit;
      frame.digit_select = DIGIT_COUNT'(1) << scan_pos;
      scan_pos = scan_pos + 1'b1;
      return frame;
   endfunction

   function automatic req_payload_type make_tick(input logic sec, input logic min_strobe,
                                                 input logic min_button, input logic hour,
                                                 input logic alarm);
      req_payload_type t;
      t.second_strobe = sec;
      t.minute_strobe = min_strobe;
      t.minute_button = min_button;
      t.hour_button   = hour;
      t.alarm_button  = alarm;
      return t;
   endfunction

   // mostly short gaps, a few long ones, and now and then a run with none
   function automatic int unsigned draw_idle(inout int unsigned calm_left);
      int unsigned r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // driver: advance to the next tick once the current one transfers
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         rsp_if.ready <= 1'b0;
      end else begin
         if (!req_if.valid || req_fire) begin
            if (send_idle > 0) begin
               send_idle--;
               req_if.valid <= 1'b0;
            end else if (tick_queue.size() != 0) begin
               req_if.payload <= tick_queue.pop_front();
               req_if.valid <= 1'b1;
               send_idle = draw_idle(send_calm);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
         if (recv_idle > 0) begin
            recv_idle--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            recv_idle = draw_idle(recv_calm);
         end
      end
   end

   // monitor: predict on each tick transfer, check each display transfer
   always @(posedge clock) begin
      req_fire <= !reset && req_if.valid && req_if.ready;
      if (reset) begin
         wall_time = '0;
         alarm_time = '0;
         colon_lit = 1'b0;
         scan_pos = POS_HOUR_TENS;
      end else begin
         if (req_if.valid && req_if.ready)
            expected_frames.push_back(render_tick(req_if.payload));
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_frames.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected transfer, segment_pattern %h digit_select %h",
                        $time, rsp_if.payload.segment_pattern, rsp_if.payload.digit_select);
            end else begin
               want = expected_frames.pop_front();
               if (rsp_if.payload.segment_pattern !== want.segment_pattern) begin
                  mismatch_count++;
                  $display("%0t: segment_pattern expected %h actual %h", $time,
                           want.segment_pattern, rsp_if.payload.segment_pattern);
               end
               if (rsp_if.payload.digit_select !== want.digit_select) begin
                  mismatch_count++;
                  $display("%0t: digit_select expected %h actual %h", $time,
                           want.digit_select, rsp_if.payload.digit_select);
               end
            end
         end
      end
   end

   initial begin
      int unsigned made;
      int unsigned run_len;
      int unsigned kind;
      logic        hold_alarm;
      logic [1:0]  src;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;

      // quiet tick, each input alone, the minute sources together, alarm combinations
      tick_queue.push_back(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
      tick_queue.push_back(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
      tick_queue.push_back(make_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
      tick_queue.push_back(make_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
      tick_queue.push_back(make_tick(1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
      tick_queue.push_back(make_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
      tick_queue.push_back(make_tick(1'b1, 1'b1, 1'b0, 1'b1, 1'b0));
      tick_queue.push_back(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
      tick_queue.push_back(make_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b1));
      tick_queue.push_back(make_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
      tick_queue.push_back(make_tick(1'b1, 1'b0, 1'b0, 1'b1, 1'b1));
      tick_queue.push_back(make_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
      // push the clock hours past nine so the tens digit lights up
      repeat (10)
         tick_queue.push_back(make_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b0));

      made = 0;
      while (made < RANDOM_TICKS) begin
         kind = $urandom_range(0, 9);
         hold_alarm = ($urandom_range(0, 2) == 0);
         if (kind < 4) begin
            // minute runs: roll the minutes over and carry into the hours
            run_len = $urandom_range(20, 70);
            repeat (run_len) begin
               src = ($urandom_range(0, 9) != 0) ? 2'($urandom_range(1, 3)) : 2'b00;
               tick_queue.push_back(make_tick(1'($urandom_range(0, 1)), src[0], src[1],
                                              $urandom_range(0, 7) == 0, hold_alarm));
            end
         end else if (kind < 6) begin
            // hour runs: reach the 23 to 00 wrap
            run_len = $urandom_range(5, 30);
            repeat (run_len) begin
               src = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 3)) : 2'b00;
               tick_queue.push_back(make_tick(1'($urandom_range(0, 1)), src[0], src[1],
                                              $urandom_range(0, 4) != 0, hold_alarm));
            end
         end else begin
            run_len = $urandom_range(5, 20);
            repeat (run_len)
               tick_queue.push_back(req_payload_type'(5'($urandom_range(0, 31))));
         end
         made += run_len;
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (tick_queue.size() != 0 || req_if.valid)
         @(posedge clock);
      while (expected_frames.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
